// ----- src/mhvs_pkg.sv -----
// shared types, constants and tables for the metallic hi-hat voice synth
package mhvs_pkg;

	localparam int VOICES_DEF = 8;
	localparam int OSCILLATORS_DEF = 6;

	localparam logic [31:0] BASE_STEP_RST = 32'd18343000;
	localparam logic [16:0] METAL_RST = 17'd72090;
	localparam logic [23:0] DECAY_RST = 24'd16774303;
	localparam logic [16:0] SVF_RST = 17'd68484;
	localparam logic [23:0] HP_RST = 24'd8719000;

	localparam logic [23:0] FULL_ENV = 24'hFFFFFF;
	localparam logic [23:0] ENV_FLOOR = 24'd168;
	localparam logic signed [15:0] TRIG_HALF = 16'sd16384;
	localparam logic signed [15:0] DAMP_Q14 = 16'sd19661;
	localparam logic signed [15:0] TANH_LIMIT = 16'sd32745;

	localparam logic [2:0] REG_BASE_STEP = 3'd0;
	localparam logic [2:0] REG_METAL = 3'd1;
	localparam logic [2:0] REG_DECAY = 3'd2;
	localparam logic [2:0] REG_SVF = 3'd3;
	localparam logic [2:0] REG_HP = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ENV,
		ST_OSC,
		ST_MIX,
		ST_LOW,
		ST_BAND,
		ST_HP,
		ST_SHAPE,
		ST_INTERP,
		ST_OUT
	} state_t;

	function automatic logic [17:0] ratio_q16(input logic [2:0] o);
		unique case (o)
			3'd0: ratio_q16 = 18'd65536;
			3'd1: ratio_q16 = 18'd97171;
			3'd2: ratio_q16 = 18'd117984;
			3'd3: ratio_q16 = 18'd166857;
			3'd4: ratio_q16 = 18'd172379;
			3'd5: ratio_q16 = 18'd255376;
			3'd6: ratio_q16 = 18'd131072;
			default: ratio_q16 = 18'd194342;
		endcase
	endfunction

	function automatic logic [14:0] tanh_q15(input logic [3:0] i);
		unique case (i)
			4'd0: tanh_q15 = 15'd0;
			4'd1: tanh_q15 = 15'd8025;
			4'd2: tanh_q15 = 15'd15142;
			4'd3: tanh_q15 = 15'd20812;
			4'd4: tanh_q15 = 15'd24955;
			4'd5: tanh_q15 = 15'd27796;
			4'd6: tanh_q15 = 15'd29659;
			4'd7: tanh_q15 = 15'd30846;
			4'd8: tanh_q15 = 15'd31588;
			4'd9: tanh_q15 = 15'd32047;
			4'd10: tanh_q15 = 15'd32328;
			4'd11: tanh_q15 = 15'd32499;
			4'd12: tanh_q15 = 15'd32605;
			4'd13: tanh_q15 = 15'd32669;
			4'd14: tanh_q15 = 15'd32707;
			default: tanh_q15 = 15'd32731;
		endcase
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) sat24 = 24'sh7FFFFF;
		else if (v < -48'sd8388608) sat24 = 24'sh800000;
		else sat24 = v[23:0];
	endfunction

endpackage

// ----- src/mhvs_ram.sv -----
// generic single-port-write ram with registered read
module mhvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- src/metallic_hihat_voice_synth_core.sv -----
// top level of the metallic hi-hat voice synth
// One request is one sample of one voice. Voice state is kept in two rams: a
// per-voice record (trigger, envelope, filter states) and a phase ram with one
// entry per voice and oscillator. After reset a clearing pass zeroes both rams
// before the first request is taken. A muted request goes from the record read
// straight to the result; a silent voice stops after the envelope step; an
// active voice also runs the oscillator steps, the filter, the shaper and the
// interpolation, with the one shared oscillator step unit taking each phase
// entry in turn. The result waits in an output register; the next request is
// taken in the cycle after the previous result has left the core, so the core
// takes no new request before it is through with the last one.
module metallic_hihat_voice_synth_core #(
	parameter int VOICES = mhvs_pkg::VOICES_DEF,
	parameter int OSCILLATORS = mhvs_pkg::OSCILLATORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // voice, trigger_level, muted, zero fill
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata,   // sample_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mhvs_pkg::*;

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int OW = (OSCILLATORS > 1) ? $clog2(OSCILLATORS) : 1;
	localparam int PD = VOICES * OSCILLATORS;
	localparam int PW = (PD > 1) ? $clog2(PD) : 1;
	localparam int RECW = 16 + 24 + 4 * 24;

	logic [31:0] base_q;
	logic [16:0] metal_q;
	logic [23:0] decay_q;
	logic [16:0] svf_q;
	logic [23:0] hpc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_STEP_RST;
			metal_q <= METAL_RST;
			decay_q <= DECAY_RST;
			svf_q <= SVF_RST;
			hpc_q <= HP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_STEP: base_q <= cfg_data;
				REG_METAL: metal_q <= cfg_data[16:0];
				REG_DECAY: decay_q <= cfg_data[23:0];
				REG_SVF: svf_q <= cfg_data[16:0];
				REG_HP: hpc_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic clr_q;
	logic [PW:0] clr_cnt_q;
	logic [VW-1:0] voice_q;
	logic signed [15:0] trig_q;
	logic muted_q;
	logic [OW:0] osc_q;
	logic [2:0] osc_phase_q;
	logic [31:0] mult_q;
	logic [33:0] step_q;
	logic signed [4:0] count_q;
	logic signed [15:0] ptrig_q;
	logic [23:0] env_q;
	logic signed [23:0] low_q, band_q, hpo_q, hpi_q;
	logic signed [23:0] x_q;
	logic signed [25:0] hpin_q;
	logic [47:0] mag_q;
	logic neg_q;
	logic [15:0] out_q;
	logic out_v_q;

	logic rec_we;
	logic [VW-1:0] rec_waddr;
	logic [RECW-1:0] rec_wdata, rec_rdata;
	logic ph_we;
	logic [PW-1:0] ph_waddr, ph_raddr;
	logic [31:0] ph_wdata, ph_rdata;

	// voice index modulo VOICES through a small constant table
	function automatic logic [VW-1:0] voice_of(input logic [2:0] r);
		voice_of = '0;
		for (int i = 0; i < 8; i++)
			if (r == 3'(i)) voice_of = VW'(i % VOICES);
	endfunction

	logic [VW-1:0] in_voice;
	logic [2:0] in_voice_raw;
	assign in_voice_raw = s_tdata[2:0];
	assign in_voice = voice_of(in_voice_raw);

	mhvs_ram #(.WIDTH(RECW), .DEPTH(VOICES)) u_rec_ram (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(s_tready ? in_voice : voice_q), .rdata(rec_rdata)
	);
	mhvs_ram #(.WIDTH(32), .DEPTH(PD)) u_phase_ram (
		.clk(clk), .we(ph_we), .waddr(ph_waddr), .wdata(ph_wdata),
		.raddr(ph_raddr), .rdata(ph_rdata)
	);

	assign s_tready = (state_q == ST_IDLE) && !clr_q && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	logic accept;
	assign accept = s_tvalid && s_tready;

	logic fire;
	logic [23:0] env_trig;
	assign fire = (trig_q > TRIG_HALF) && (ptrig_q <= TRIG_HALF);
	assign env_trig = fire ? FULL_ENV : env_q;

	// oscillator sub-steps: 0 issue read, 1 step*ratio, 2 step*m, 3 add + m update
	logic [49:0] prod_a;
	logic [65:0] prod_b;
	logic [31:0] newph;
	assign prod_a = {18'd0, base_q} * {32'd0, ratio_q16(3'(osc_q))};
	assign prod_b = {32'd0, step_q} * {34'd0, mult_q};
	assign newph = ph_rdata + step_q[31:0];
	assign ph_raddr = PW'(32'(voice_q) * OSCILLATORS + 32'(osc_q));

	logic signed [47:0] t_low, t_damp, t_band;
	logic signed [25:0] hp_arg;
	logic signed [51:0] t_hp;
	assign t_low = $signed({7'd0, svf_q}) * band_q;
	assign t_damp = band_q * DAMP_Q14;
	assign t_band = $signed({7'd0, svf_q}) * hpin_q;
	assign hp_arg = 26'(hpo_q) + 26'(band_q) - 26'(hpi_q);
	assign t_hp = $signed({28'd0, hpc_q}) * hp_arg;

	logic signed [47:0] shp_p;
	assign shp_p = hpo_q * $signed({1'b0, env_q});
	logic [49:0] arg3;
	logic [25:0] arg;
	assign arg3 = {2'd0, mag_q} * 50'd3;
	assign arg = 26'(arg3 >> 24);
	logic [3:0] tidx;
	logic [17:0] tfrac;
	logic [14:0] ta, tb;
	logic [32:0] tprod;
	logic [14:0] ty;
	assign tidx = arg[21:18];
	assign tfrac = arg[17:0];
	assign ta = tanh_q15(tidx);
	assign tb = (tidx == 4'd15) ? 15'(TANH_LIMIT) : tanh_q15(tidx + 4'd1);
	assign tprod = {18'd0, tb - ta} * {15'd0, tfrac};
	assign ty = (arg[25:22] != 4'd0) ? 15'(TANH_LIMIT) : ta + 15'(tprod >> 18);

	// x = count * 2^20 / OSCILLATORS through a small constant table
	function automatic logic signed [23:0] mix_of(input logic signed [4:0] c);
		mix_of = '0;
		for (int i = -8; i <= 8; i++)
			if (c == 5'(i)) mix_of = 24'((i * 1048576) / OSCILLATORS);
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_READ;
			ST_READ: state_d = muted_q ? ST_OUT : ST_ENV;
			ST_ENV: state_d = (env_trig < ENV_FLOOR) ? ST_OUT : ST_OSC;
			ST_OSC: if (osc_phase_q == 3'd3 && osc_q == (OW+1)'(OSCILLATORS - 1))
				state_d = ST_MIX;
			ST_MIX: state_d = ST_LOW;
			ST_LOW: state_d = ST_BAND;
			ST_BAND: state_d = ST_HP;
			ST_HP: state_d = ST_SHAPE;
			ST_SHAPE: state_d = ST_INTERP;
			ST_INTERP: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rec_we = 1'b0;
		rec_waddr = voice_q;
		rec_wdata = {ptrig_q, env_q, low_q, band_q, hpo_q, hpi_q};
		ph_we = 1'b0;
		ph_waddr = ph_raddr;
		ph_wdata = newph;
		if (clr_q) begin
			rec_we = (clr_cnt_q < (PW+1)'(VOICES));
			rec_waddr = clr_cnt_q[VW-1:0];
			rec_wdata = '0;
			ph_we = 1'b1;
			ph_waddr = clr_cnt_q[PW-1:0];
			ph_wdata = '0;
		end else if (state_q == ST_ENV && env_trig < ENV_FLOOR) begin
			rec_we = 1'b1;
			rec_wdata = {trig_q, env_trig, low_q, band_q, hpo_q, hpi_q};
		end else if (state_q == ST_OSC && osc_phase_q == 3'd3) begin
			ph_we = 1'b1;
		end else if (state_q == ST_HP) begin
			rec_we = 1'b1;
			rec_wdata = {ptrig_q, env_q, low_q, band_q, sat24(48'(t_hp >>> 24)), band_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (PW+1)'(PD - 1)) clr_q <= 1'b0;
			end
			if (state_q == ST_OUT) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			voice_q <= in_voice;
			trig_q <= s_tdata[18:3];
			muted_q <= s_tdata[19];
		end
		unique case (state_q)
			ST_READ: begin
				{ptrig_q, env_q, low_q, band_q, hpo_q, hpi_q} <= rec_rdata;
				out_q <= '0;
				osc_q <= '0;
				osc_phase_q <= '0;
				mult_q <= 32'd65536;
				count_q <= '0;
			end
			ST_ENV: begin
				ptrig_q <= trig_q;
				env_q <= 24'(({24'd0, env_trig} * {24'd0, decay_q}) >> 24);
			end
			ST_OSC: begin
				unique case (osc_phase_q)
					3'd0: osc_phase_q <= 3'd1;
					3'd1: begin
						step_q <= prod_a[49:16];
						osc_phase_q <= 3'd2;
					end
					3'd2: begin
						step_q <= {2'd0, prod_b[47:16]};
						osc_phase_q <= 3'd3;
					end
					default: begin
						count_q <= newph[31] ? count_q - 5'sd1 : count_q + 5'sd1;
						mult_q <= 32'(({32'd0, mult_q} * {47'd0, metal_q}) >> 16);
						osc_q <= osc_q + 1'b1;
						osc_phase_q <= 3'd0;
					end
				endcase
			end
			ST_MIX: begin
				x_q <= mix_of(count_q);
				low_q <= sat24(48'(low_q) + (t_low >>> 16));
			end
			ST_LOW: hpin_q <= 26'(x_q) - 26'(low_q) - 26'(t_damp >>> 14);
			ST_BAND: band_q <= sat24(48'(band_q) + (t_band >>> 16));
			ST_HP: hpo_q <= sat24(48'(t_hp >>> 24));
			ST_SHAPE: begin
				neg_q <= shp_p < 0;
				mag_q <= (shp_p < 0) ? 48'(-shp_p) : 48'(shp_p);
			end
			ST_INTERP: out_q <= neg_q ? -{1'b0, ty} : {1'b0, ty};
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s_tready) else $error("request taken during clear");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> m_tvalid) else $error("result not presented");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif
endmodule
